// ===== src/two_pkg.sv =====
// two_pkg: shared types, register indexes and the sine table builder for
// the tone waveform oscillator. No dependencies.
package two_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_WAVE_SHAPE      = 3'd0;
  localparam logic [2:0] REG_PHASE_INCREMENT = 3'd1;
  localparam logic [2:0] REG_GAIN            = 3'd2;
  localparam logic [2:0] REG_CHANNEL_COUNT   = 3'd3;
  localparam logic [2:0] REG_FRAME_TOTAL     = 3'd4;

  // Wave shape codes
  localparam logic [1:0] SHAPE_SINE     = 2'd0;
  localparam logic [1:0] SHAPE_SQUARE   = 2'd1;
  localparam logic [1:0] SHAPE_SAW      = 2'd2;
  localparam logic [1:0] SHAPE_TRIANGLE = 2'd3;

  // Reset values of the registers
  localparam logic [1:0]  RST_WAVE_SHAPE      = SHAPE_SINE;
  localparam logic [31:0] RST_PHASE_INCREMENT = 32'd39370534;
  localparam logic [15:0] RST_GAIN            = 16'd16384;
  localparam logic [3:0]  RST_CHANNEL_COUNT   = 4'd1;
  localparam logic [31:0] RST_FRAME_TOTAL     = 32'd48000;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Frame descriptor between the request register and the frame register
  typedef struct packed {
    logic [31:0] phase;
    logic        clip_end;
    logic        past_end;
  } req_t;

  // unsigned 64-bit quotient by restoring shift-subtract; elaboration only
  function automatic logic [63:0] udiv_u64(input logic [63:0] num,
                                           input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(32768*sin(pi/2*k/2^qbits)) from a Q30 Taylor series; elaboration only
  function automatic logic [16:0] sine_entry(input int unsigned k,
                                             input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] div;
    x    = (PI_HALF_Q30 * 64'(k)) >> qbits;
    term = x;
    sum  = x;
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      div  = 64'((2 * n) * (2 * n + 1));
      term = udiv_u64(term, div);
      if ((n & 1) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return 17'((sum + 64'd16384) >> 15);
  endfunction

endpackage

// ===== src/tone_waveform_oscillator.sv =====
// tone_waveform_oscillator: DDS tone generator, phase accumulator, wave
// select, gain and saturation, channel fan-out. Depends on two_pkg.
//
//  channel   dir  tdata                      tuser                         tlast
//  s_axis    in   [0] restart                -                             -
//  m_axis    out  [SAMPLE_BITS-1:0] sample   [2:0] channel, [3] clip_end,  last_of_frame
//                                            [4] past_end
//  cfg       in   write port: cfg_we_i, cfg_addr_i (register index), cfg_wdata_i
//
// Request register -> sample built by combinational logic (table read, multiply,
// round, saturate) -> frame register -> one channel word per cycle on m_axis
// while m_axis_tready is high. channel_count is clamped to 1..MAX_CHANNELS; the
// first word passes the request, frame and output registers after acceptance.
// Reset clears phase, frame counter, valids and the registers to defaults.
// A stalled output holds its word; one request waits behind a busy frame register.
module tone_waveform_oscillator #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16,
  parameter int MAX_CHANNELS    = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave: frame requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [0] restart
  // master: channel samples
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [(((SAMPLE_BITS+7)>>3)<<3)-1:0] m_axis_tdata,  // sample
  output logic [4:0]                          m_axis_tuser,   // channel, clip_end, past_end
  output logic                                m_axis_tlast,   // last_of_frame
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_addr_i,
  input  logic [31:0]                         cfg_wdata_i
);

  localparam int QLEN    = 1 << (SINE_TABLE_BITS - 2);
  localparam int SHIFT   = 31 - SAMPLE_BITS;
  localparam int TDATA_W = ((SAMPLE_BITS + 7) >> 3) << 3;
  localparam logic signed [35:0] SAT_HI = 36'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;
  localparam logic signed [35:0] RND    = 36'(64'sd1 <<< (SHIFT - 1));

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [1:0]  shape_q;
  logic [31:0] incr_q;
  logic [15:0] gain_q;
  logic [3:0]  chans_q;
  logic [31:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= two_pkg::RST_WAVE_SHAPE;
      incr_q  <= two_pkg::RST_PHASE_INCREMENT;
      gain_q  <= two_pkg::RST_GAIN;
      chans_q <= two_pkg::RST_CHANNEL_COUNT;
      total_q <= two_pkg::RST_FRAME_TOTAL;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        two_pkg::REG_WAVE_SHAPE:      shape_q <= cfg_wdata_i[1:0];
        two_pkg::REG_PHASE_INCREMENT: incr_q  <= cfg_wdata_i;
        two_pkg::REG_GAIN:            gain_q  <= cfg_wdata_i[15:0];
        two_pkg::REG_CHANNEL_COUNT:   chans_q <= cfg_wdata_i[3:0];
        two_pkg::REG_FRAME_TOTAL:     total_q <= cfg_wdata_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Effective channel count clamped to 1..MAX_CHANNELS, as last index
  logic [2:0] last_ch;
  always_comb begin
    if (chans_q == 4'd0) begin
      last_ch = 3'd0;
    end else if (chans_q > 4'(MAX_CHANNELS)) begin
      last_ch = 3'(MAX_CHANNELS - 1);
    end else begin
      last_ch = 3'(chans_q - 4'd1);
    end
  end

  // ---------------------------------------------------------------------
  // Handshake chain: request reg -> frame reg -> output reg
  // ---------------------------------------------------------------------
  logic        req_valid_q, req_valid_d;
  two_pkg::req_t req_q;
  logic        fr_valid_q, fr_valid_d;
  logic [SAMPLE_BITS-1:0] fr_sample_q;
  logic        fr_clip_q, fr_past_q;
  logic [2:0]  ch_q, ch_d;
  logic        out_load, fr_last, fr_ready, fr_load, s_accept;

  assign out_load      = fr_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign fr_last       = (ch_q == last_ch);
  assign fr_ready      = !fr_valid_q || (out_load && fr_last);
  assign fr_load       = req_valid_q && fr_ready;
  assign s_axis_tready = !req_valid_q || fr_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------
  // Phase accumulator and frame counter, advanced per accepted request before the frame total
  // ---------------------------------------------------------------------
  logic [31:0] phase_q, phase_d, cnt_q, cnt_d;
  logic [31:0] ph_base, cnt_base;
  logic        past_now;
  two_pkg::req_t req_d;

  always_comb begin
    ph_base  = s_axis_tdata[0] ? 32'd0 : phase_q;
    cnt_base = s_axis_tdata[0] ? 32'd0 : cnt_q;
    past_now = (cnt_base >= total_q);
    req_d.phase    = ph_base;
    req_d.past_end = past_now;
    req_d.clip_end = !past_now && ((cnt_base + 32'd1) == total_q);
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (s_accept) begin
      phase_d = past_now ? ph_base : ph_base + incr_q;
      cnt_d   = past_now ? cnt_base : cnt_base + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      cnt_q       <= '0;
      req_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      req_valid_q <= req_valid_d;
    end
  end

  assign req_valid_d = s_accept || (req_valid_q && !fr_ready);

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_q <= req_d;
    end
  end

  // ---------------------------------------------------------------------
  // Wave value: quarter-wave sine table, square, saw, triangle
  // ---------------------------------------------------------------------
  logic [16:0] sine_lut [QLEN+1];

  for (genvar k = 0; k <= QLEN; k++) begin : g_lut
    localparam logic [16:0] ENTRY =
      two_pkg::sine_entry(k, SINE_TABLE_BITS - 2);
    assign sine_lut[k] = ENTRY;
  end

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS-3:0] pos;
  logic [SINE_TABLE_BITS-2:0] lut_idx;
  logic [16:0]                mag;
  logic [31:0]                tri_dist;
  logic signed [17:0]         wave;

  always_comb begin
    idx      = req_q.phase[31 -: SINE_TABLE_BITS];
    pos      = idx[SINE_TABLE_BITS-3:0];
    lut_idx  = idx[SINE_TABLE_BITS-2] ? (SINE_TABLE_BITS-1)'(QLEN) - {1'b0, pos}
                                      : {1'b0, pos};
    mag      = sine_lut[lut_idx];
    tri_dist = req_q.phase[31] ? {1'b0, req_q.phase[30:0]}
                               : 32'h8000_0000 - req_q.phase;
    unique case (shape_q)
      two_pkg::SHAPE_SINE:
        wave = idx[SINE_TABLE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      two_pkg::SHAPE_SQUARE:
        wave = req_q.phase[31] ? -18'sd32768 : 18'sd32768;
      two_pkg::SHAPE_SAW:
        wave = $signed({2'b00, req_q.phase[31:16]}) - 18'sd32768;
      two_pkg::SHAPE_TRIANGLE:
        wave = $signed({1'b0, tri_dist[31:15]}) - 18'sd32768;
      default: wave = '0;
    endcase
  end

  // Gain, round half up, floor shift, saturate; zero past the end
  logic signed [34:0] prod;
  logic signed [35:0] prod_rnd, shifted;
  logic [SAMPLE_BITS-1:0] sample_d;

  always_comb begin
    prod     = wave * $signed({1'b0, gain_q});
    prod_rnd = {prod[34], prod} + RND;
    shifted  = prod_rnd >>> SHIFT;
    if (req_q.past_end) begin
      sample_d = '0;
    end else if (shifted > SAT_HI) begin
      sample_d = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      sample_d = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sample_d = shifted[SAMPLE_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Frame register with channel counter
  // ---------------------------------------------------------------------
  always_comb begin
    fr_valid_d = fr_valid_q;
    ch_d       = ch_q;
    if (out_load) begin
      if (fr_last) begin
        fr_valid_d = 1'b0;
      end else begin
        ch_d = ch_q + 3'd1;
      end
    end
    if (fr_load) begin
      fr_valid_d = 1'b1;
      ch_d       = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
      ch_q       <= '0;
    end else begin
      fr_valid_q <= fr_valid_d;
      ch_q       <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fr_load) begin
      fr_sample_q <= sample_d;
      fr_clip_q   <= req_q.clip_end;
      fr_past_q   <= req_q.past_end;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= TDATA_W'(fr_sample_q);
      m_axis_tuser <= {fr_past_q, fr_clip_q, ch_q};
      m_axis_tlast <= fr_last;
    end
  end

`ifndef NO_ASSERTIONS
  // beyond the clip the word is zero and never marks the clip end
  a_past_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[4] |-> (m_axis_tdata == '0) && !m_axis_tuser[3])
    else $error("past_end word with nonzero sample or clip_end");

  // tlast marks exactly the final channel of the configured count
  a_last_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[2:0] == last_ch)))
    else $error("tlast disagrees with channel index");

  // request side only stalls while a request waits for the frame register
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> req_valid_q && fr_valid_q)
    else $error("request stalled with free pipeline");

  // phase and frame counter hold unless a request is accepted
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_accept |=> $stable(cnt_q) && $stable(phase_q))
    else $error("phase or frame counter moved without a request");
`endif

endmodule
